// ===== hdl/bhpq_pkg.sv =====
`default_nettype none

package bhpq_pkg;

  // field widths fixed by the interface
  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CAP_W = 7;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned CFG_ADDR_W = 1;

  // defaults
  localparam int unsigned DEF_HEAP_DEPTH = 64;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 1'b1;

  // request operations
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_WRITE   = 2'd2,
    OP_REBUILD = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } stat_e;

  // controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  up_init;
    logic  up_read;
    logic  up_move;
    logic  up_place;
    logic  ex_read;
    logic  ex_load;
    logic  dn_read;
    logic  dn_move;
    logic  dn_place;
    logic  wr_entry;
    logic  rb_init;
    logic  rb_read;
    logic  rb_load;
    logic  finish;
    stat_e status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_bad;
    logic pos_zero;
    logic up_beats;
    logic leaf;
    logic dn_beats;
    logic k_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/bhpq_ram.sv =====
`default_nettype none

module bhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== hdl/bhpq_dp.sv =====
`default_nettype none

module bhpq_dp #(
  parameter int unsigned HEAP_DEPTH = bhpq_pkg::DEF_HEAP_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bhpq_pkg::cmd_t                  cmd_i,
  output bhpq_pkg::sts_t                       sts_o,
  input  wire logic                            order_mode_i,
  input  wire logic [bhpq_pkg::CAP_W-1:0]      capacity_i,
  input  wire logic [bhpq_pkg::KEY_W-1:0]      key_value_i,
  input  wire logic [bhpq_pkg::IDX_W-1:0]      entry_index_i,
  output logic                                 done_o,
  output logic [bhpq_pkg::KEY_W-1:0]           removed_key_o,
  output logic [1:0]                           status_o,
  output logic [bhpq_pkg::CNT_OUT_W-1:0]       entry_count_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned CMPW = (CW > bhpq_pkg::CAP_W) ? CW : bhpq_pkg::CAP_W;
  localparam int unsigned IXW = (CW > bhpq_pkg::IDX_W) ? CW : bhpq_pkg::IDX_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(HEAP_DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] k_q, k_d;
  logic signed [bhpq_pkg::KEY_W-1:0] val_q, val_d;
  logic [bhpq_pkg::KEY_W-1:0] key_q;
  logic [bhpq_pkg::IDX_W-1:0] idx_q;
  logic [bhpq_pkg::KEY_W-1:0] removed_q, removed_d;
  logic done_q;
  logic [1:0] status_q;
  logic [bhpq_pkg::CNT_OUT_W-1:0] cnt_out_q;

  logic we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [bhpq_pkg::KEY_W-1:0] wdata, rdata_a, rdata_b;
  logic signed [bhpq_pkg::KEY_W-1:0] rd_a, rd_b, pick_val;

  logic [CMPW-1:0] cap;
  logic [AW-1:0] parent, k_dec, pick;
  logic [LW-1:0] lchild, rchild;
  logic r_live, sel_right;

  // true if key a belongs strictly above key b
  function automatic logic beats(input logic signed [bhpq_pkg::KEY_W-1:0] a,
                                 input logic signed [bhpq_pkg::KEY_W-1:0] b,
                                 input logic mode);
    beats = mode ? (a < b) : (a > b);
  endfunction

  bhpq_ram #(
    .WIDTH (bhpq_pkg::KEY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign rd_a = rdata_a;
  assign rd_b = rdata_b;

  // index arithmetic
  assign parent = (pos_q - AW'(1)) >> 1;
  assign lchild = (LW'(pos_q) << 1) + LW'(1);
  assign rchild = lchild + LW'(1);
  assign k_dec = k_q - AW'(1);
  assign r_live = rchild < LW'(count_q);
  assign sel_right = r_live && !beats(rd_a, rd_b, order_mode_i);
  assign pick = sel_right ? AW'(rchild) : AW'(lchild);
  assign pick_val = sel_right ? rd_b : rd_a;

  // effective capacity is the smaller of the register and the array depth
  assign cap = (CMPW'(capacity_i) < DEPTH_C) ? CMPW'(capacity_i) : DEPTH_C;

  // status back to the controller
  always_comb begin
    sts_o.full = CMPW'(count_q) >= cap;
    sts_o.empty = count_q == '0;
    sts_o.idx_bad = IXW'(idx_q) >= IXW'(count_q);
    sts_o.pos_zero = pos_q == '0;
    sts_o.up_beats = beats(val_q, rd_a, order_mode_i);
    sts_o.leaf = lchild >= LW'(count_q);
    sts_o.dn_beats = beats(pick_val, val_q, order_mode_i);
    sts_o.k_zero = k_q == '0;
  end

  // memory read addresses
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.up_read) begin
      raddr_a = parent;
    end else if (cmd_i.ex_read) begin
      raddr_a = '0;
      raddr_b = AW'(count_q - CW'(1));
    end else if (cmd_i.dn_read) begin
      raddr_a = AW'(lchild);
      raddr_b = AW'(rchild);
    end else if (cmd_i.rb_read) begin
      raddr_a = k_dec;
    end
  end

  // memory write port
  always_comb begin
    we = 1'b0;
    waddr = pos_q;
    wdata = val_q;
    if (cmd_i.wr_entry) begin
      we = 1'b1;
      waddr = AW'(idx_q);
      wdata = key_q;
    end else if (cmd_i.up_move) begin
      we = 1'b1;
      wdata = rd_a;
    end else if (cmd_i.dn_move) begin
      we = 1'b1;
      wdata = pick_val;
    end else if (cmd_i.up_place || cmd_i.dn_place) begin
      we = 1'b1;
    end
  end

  // working register updates
  always_comb begin
    count_d = count_q;
    pos_d = pos_q;
    k_d = k_q;
    val_d = val_q;
    removed_d = removed_q;
    if (cmd_i.load) begin
      removed_d = '0;
    end
    if (cmd_i.up_init) begin
      pos_d = AW'(count_q);
      val_d = key_q;
    end
    if (cmd_i.up_move) begin
      pos_d = parent;
    end
    if (cmd_i.up_place) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.ex_load) begin
      removed_d = rd_a;
      val_d = rd_b;
      count_d = count_q - CW'(1);
      pos_d = '0;
    end
    if (cmd_i.dn_move) begin
      pos_d = pick;
    end
    if (cmd_i.rb_init) begin
      k_d = AW'(count_q >> 1);
    end
    if (cmd_i.rb_read) begin
      k_d = k_dec;
      pos_d = k_dec;
    end
    if (cmd_i.rb_load) begin
      val_d = rd_a;
    end
  end

  // control state: live count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q <= cmd_i.finish;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    k_q <= k_d;
    val_q <= val_d;
    removed_q <= removed_d;
    if (cmd_i.load) begin
      key_q <= key_value_i;
      idx_q <= entry_index_i;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      cnt_out_q <= bhpq_pkg::CNT_OUT_W'(count_d);
    end
  end

  assign done_o = done_q;
  assign removed_key_o = removed_q;
  assign status_o = status_q;
  assign entry_count_o = cnt_out_q;

endmodule

`default_nettype wire

// ===== hdl/bhpq_ctrl.sv =====
`default_nettype none

module bhpq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [1:0]     operation_i,
  input  wire bhpq_pkg::sts_t sts_i,
  output bhpq_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_UP_CHK   = 9'b000000100,
    S_UP_EV    = 9'b000001000,
    S_EX_LD    = 9'b000010000,
    S_DN_CHK   = 9'b000100000,
    S_DN_EV    = 9'b001000000,
    S_RB_NEXT  = 9'b010000000,
    S_RB_LD    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  bhpq_pkg::op_e op_q, op_d;

  // sequencing of the heap walks
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    cmd_o = '0;
    cmd_o.status = bhpq_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          op_d = bhpq_pkg::op_e'(operation_i);
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          bhpq_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bhpq_pkg::ST_FULL;
              state_d = S_IDLE;
            end else begin
              cmd_o.up_init = 1'b1;
              state_d = S_UP_CHK;
            end
          end
          bhpq_pkg::OP_EXTRACT: begin
            if (sts_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = bhpq_pkg::ST_EMPTY;
              state_d = S_IDLE;
            end else begin
              cmd_o.ex_read = 1'b1;
              state_d = S_EX_LD;
            end
          end
          bhpq_pkg::OP_WRITE: begin
            cmd_o.finish = 1'b1;
            if (sts_i.idx_bad) begin
              cmd_o.status = bhpq_pkg::ST_RANGE;
            end else begin
              cmd_o.wr_entry = 1'b1;
            end
            state_d = S_IDLE;
          end
          bhpq_pkg::OP_REBUILD: begin
            cmd_o.rb_init = 1'b1;
            state_d = S_RB_NEXT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      // sift up: read parent, then move it down or place the key
      S_UP_CHK: begin
        if (sts_i.pos_zero) begin
          cmd_o.up_place = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.up_read = 1'b1;
          state_d = S_UP_EV;
        end
      end
      S_UP_EV: begin
        if (sts_i.up_beats) begin
          cmd_o.up_move = 1'b1;
          state_d = S_UP_CHK;
        end else begin
          cmd_o.up_place = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EX_LD: begin
        cmd_o.ex_load = 1'b1;
        state_d = S_DN_CHK;
      end
      // sift down: read both children, then move the winner up or place the key
      S_DN_CHK: begin
        if (sts_i.leaf) begin
          cmd_o.dn_place = 1'b1;
          if (op_q == bhpq_pkg::OP_REBUILD) begin
            state_d = S_RB_NEXT;
          end else begin
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.dn_read = 1'b1;
          state_d = S_DN_EV;
        end
      end
      S_DN_EV: begin
        if (sts_i.dn_beats) begin
          cmd_o.dn_move = 1'b1;
          state_d = S_DN_CHK;
        end else begin
          cmd_o.dn_place = 1'b1;
          if (op_q == bhpq_pkg::OP_REBUILD) begin
            state_d = S_RB_NEXT;
          end else begin
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      // rebuild: walk non-leaf nodes from the last one back to the root
      S_RB_NEXT: begin
        if (sts_i.k_zero) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rb_read = 1'b1;
          state_d = S_RB_LD;
        end
      end
      S_RB_LD: begin
        cmd_o.rb_load = 1'b1;
        state_d = S_DN_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= bhpq_pkg::OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

`default_nettype wire

// ===== hdl/binary_heap_priority_queue_core.sv =====
`default_nettype none

// Binary heap priority queue of signed 32-bit keys in a RAM of HEAP_DEPTH entries.
// Request channel: drive operation_i, key_value_i and entry_index_i with start
// high; the request is taken at a clock edge where start is high and busy is low.
// Result channel: done_o is high for exactly one cycle with removed_key_o,
// status_o and entry_count_o valid; the receiver cannot stall it.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 order mode, 1 capacity); write only while busy is low and no result is due.
// A refused insert, an empty extract and an entry write end in dispatch; an
// insert climbs the new key from the new slot until it stops or reaches the root;
// an extract moves the last key to the root and sinks it; a rebuild sinks each
// non-leaf node in turn, from the last one back to the root.
// Each level costs a registered RAM read followed by a compare and one write.
// One request is in work at a time; the next is taken once busy falls,
// which happens in the cycle the result is shown.
// Reset empties the heap, sets max order and a capacity of 64; entry
// contents are not cleared.
module binary_heap_priority_queue_core #(
  parameter int unsigned HEAP_DEPTH = bhpq_pkg::DEF_HEAP_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          operation_i,
  input  wire logic signed [bhpq_pkg::KEY_W-1:0]   key_value_i,
  input  wire logic [bhpq_pkg::IDX_W-1:0]          entry_index_i,
  output logic                                     done_o,
  output logic signed [bhpq_pkg::KEY_W-1:0]        removed_key_o,
  output logic [1:0]                               status_o,
  output logic [bhpq_pkg::CNT_OUT_W-1:0]           entry_count_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [bhpq_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [bhpq_pkg::CFG_W-1:0]          cfg_wdata_i
);

  logic order_mode_q;
  logic [bhpq_pkg::CAP_W-1:0] capacity_q;
  bhpq_pkg::cmd_t cmd;
  bhpq_pkg::sts_t sts;
  logic [bhpq_pkg::KEY_W-1:0] removed_key;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
      capacity_q <= bhpq_pkg::CAPACITY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bhpq_pkg::CFG_ORDER_MODE: order_mode_q <= cfg_wdata_i[0];
        bhpq_pkg::CFG_CAPACITY:   capacity_q <= cfg_wdata_i[bhpq_pkg::CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  bhpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .order_mode_i  (order_mode_q),
    .capacity_i    (capacity_q),
    .key_value_i   (key_value_i),
    .entry_index_i (entry_index_i),
    .done_o        (done_o),
    .removed_key_o (removed_key),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  assign removed_key_o = removed_key;

  // a result always shows with the engine already free
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

  // an accepted request makes the engine busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request accepted but engine not busy");

  // failed requests never return a key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != bhpq_pkg::ST_OK)) |-> (removed_key_o == '0))
    else $error("nonzero key with error status");

  // the live count never passes the array depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(entry_count_o) <= 32'(HEAP_DEPTH)))
    else $error("entry count above depth");

endmodule

`default_nettype wire
